// File: design/rxpool_pkg.sv
// Package for the receive frame pool: status and opcode codes, FCS residue
// constants and the classifier result type. No dependencies.
`default_nettype none

package rxpool_pkg;

	localparam int LEN_W = 12;
	localparam int CNT_W = 32;
	localparam int APB_AW = 2;

	localparam logic [APB_AW-1:0] ADDR_MAX_LEN = 2'd0;
	localparam logic [LEN_W-1:0] RESET_MAX_LEN = 12'd1536;

	localparam logic [31:0] RES_TRIM0 = 32'hc704dd7b;
	localparam logic [31:0] RES_TRIM3 = 32'h8104c946;
	localparam logic [31:0] RES_TRIM2 = 32'h3a7abc72;
	localparam logic [31:0] RES_TRIM1 = 32'h4710bb9c;

	typedef enum logic [1:0] {
		OP_PKT_END = 2'd0,
		OP_TAKE    = 2'd1,
		OP_RETURN  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_QUEUED   = 3'd0,
		ST_OVERRUN  = 3'd1,
		ST_FCS      = 3'd2,
		ST_OVERSIZE = 3'd3,
		ST_GIVEN    = 3'd4,
		ST_NONE     = 3'd5,
		ST_RETURNED = 3'd6
	} status_t;

	typedef struct packed {
		logic             match;
		logic             oversize;
		logic [LEN_W-1:0] length;
	} fcs_cls_t;

endpackage

`default_nettype wire

// File: design/rxpool_link_mem.sv
// Next-link memory of the frame pool, one read port with registered data.
// Valid bits make unwritten entries read as the initial free chain.
`default_nettype none

module rxpool_link_mem #(
	parameter int FRAME_COUNT = 8
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               rd_en,
	input  wire logic [$clog2(FRAME_COUNT)-1:0]     rd_addr,
	output logic      [$clog2(FRAME_COUNT+1)-1:0]   rd_data,
	input  wire logic                               wr_en,
	input  wire logic [$clog2(FRAME_COUNT)-1:0]     wr_addr,
	input  wire logic [$clog2(FRAME_COUNT+1)-1:0]   wr_data
);

	localparam int FW = $clog2(FRAME_COUNT);
	localparam int LW = $clog2(FRAME_COUNT + 1);
	localparam logic [LW-1:0] NIL = LW'(FRAME_COUNT);

	logic [LW-1:0] mem [FRAME_COUNT];
	logic [FRAME_COUNT-1:0] vld_q;
	logic [LW-1:0] data_s1;
	logic [FW-1:0] addr_s1;
	logic vld_s1;
	logic [LW-1:0] init_link;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			data_s1 <= mem[rd_addr];
			vld_s1  <= vld_q[rd_addr];
			addr_s1 <= rd_addr;
		end
	end

	always_comb begin
		if (addr_s1 == '0 || int'(addr_s1) + 1 >= FRAME_COUNT) begin
			init_link = NIL;
		end else begin
			init_link = LW'(addr_s1) + LW'(1);
		end
		rd_data = vld_s1 ? data_s1 : init_link;
	end

endmodule

`default_nettype wire

// File: design/rxpool_len_mem.sv
// Frame length memory, one read port with registered data.
// Depends on rxpool_pkg for the length width.
`default_nettype none

module rxpool_len_mem #(
	parameter int FRAME_COUNT = 8
) (
	input  wire logic                              clk,
	input  wire logic                              rd_en,
	input  wire logic [$clog2(FRAME_COUNT)-1:0]    rd_addr,
	output logic      [rxpool_pkg::LEN_W-1:0]      rd_data,
	input  wire logic                              wr_en,
	input  wire logic [$clog2(FRAME_COUNT)-1:0]    wr_addr,
	input  wire logic [rxpool_pkg::LEN_W-1:0]      wr_data
);

	logic [rxpool_pkg::LEN_W-1:0] mem [FRAME_COUNT];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: design/rxpool_fcs_check.sv
// FCS residue decode, pad trim and length limit check for one packet end.
// Depends on rxpool_pkg for the residue constants and result type.
`default_nettype none

module rxpool_fcs_check #(
	parameter int MAX_BYTES = 2048
) (
	input  wire logic [rxpool_pkg::LEN_W-1:0] byte_count,
	input  wire logic [31:0]                  crc_residue,
	input  wire logic [rxpool_pkg::LEN_W-1:0] max_len,
	output rxpool_pkg::fcs_cls_t              cls
);

	localparam int SAT = (MAX_BYTES > 4095) ? 4095 : MAX_BYTES;
	localparam logic [rxpool_pkg::LEN_W-1:0] SAT_L = rxpool_pkg::LEN_W'(SAT);

	logic [rxpool_pkg::LEN_W-1:0] count_sat;
	logic [rxpool_pkg::LEN_W-1:0] diff;
	logic [1:0] trim;
	logic match;
	logic underflow;

	always_comb begin
		count_sat = (byte_count > SAT_L) ? SAT_L : byte_count;
		match = 1'b1;
		case (crc_residue)
			rxpool_pkg::RES_TRIM0: trim = 2'd0;
			rxpool_pkg::RES_TRIM3: trim = 2'd3;
			rxpool_pkg::RES_TRIM2: trim = 2'd2;
			rxpool_pkg::RES_TRIM1: trim = 2'd1;
			default: begin
				trim  = 2'd0;
				match = 1'b0;
			end
		endcase
		underflow = count_sat < rxpool_pkg::LEN_W'(trim);
		diff = count_sat - rxpool_pkg::LEN_W'(trim);
		cls.match = match;
		cls.oversize = underflow || (diff >= max_len);
		if (!match) begin
			cls.length = count_sat;
		end else if (underflow) begin
			cls.length = '0;
		end else begin
			cls.length = diff;
		end
	end

endmodule

`default_nettype wire

// File: design/mac_rx_frame_pool_fcs_check_top.sv
// Receive frame buffer pool with FCS residue check for an Ethernet MAC.
// Depends on rxpool_pkg, rxpool_link_mem, rxpool_len_mem, rxpool_fcs_check.
//
// The input channel carries one command word: a packet end (swap the filling
// frame for one popped from the free stack, check its residue and length and
// queue or free it), a take of the oldest ready frame, or a frame return.
// Every word yields exactly one result word on the output channel, with the
// status, the frame concerned, its length and the four statistic counters.
// The maximum frame length is written through the APB port at address 0.
// A word is handled in a read step, which reads the link and length memories,
// and an update step, which updates them and loads the result register; a
// packet end that appends behind another ready frame adds a further step for
// the second write to the link memory, which has only one write port.
// While the result register is still stalled, the block holds the next word
// in its update step and does not take another.
// After reset the pool reads as frame 0 filling, frames 1 up to the last on
// the free stack and an empty ready list; no clearing pass is needed.
`default_nettype none

module mac_rx_frame_pool_fcs_check_top #(
	parameter int FRAME_COUNT = 8,
	parameter int MAX_BYTES = 2048
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [rxpool_pkg::APB_AW-1:0]     paddr,
	input  wire logic [31:0]                       pwdata,
	output logic      [31:0]                       prdata,
	output logic                                   pready,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [1:0]                        opcode,
	input  wire logic [11:0]                       byte_count,
	input  wire logic [31:0]                       crc_residue,
	input  wire logic [2:0]                        frame_index,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [2:0]                        status,
	output logic      [2:0]                        result_frame,
	output logic      [11:0]                       result_length,
	output logic      [31:0]                       good_packets,
	output logic      [31:0]                       overrun_count,
	output logic      [31:0]                       fcs_error_count,
	output logic      [31:0]                       oversize_count
);

	localparam int FW = $clog2(FRAME_COUNT);
	localparam int LW = $clog2(FRAME_COUNT + 1);
	localparam logic [LW-1:0] NIL = LW'(FRAME_COUNT);
	localparam int LEN_W = rxpool_pkg::LEN_W;
	localparam int CNT_W = rxpool_pkg::CNT_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_LINK2
	} state_t;

	state_t state_q, state_d;
	rxpool_pkg::op_t op_q;
	logic [LEN_W-1:0] count_q;
	logic [31:0] residue_q;
	logic [2:0] fidx_q;
	logic [LEN_W-1:0] max_len_q;

	logic [LW-1:0] free_head_q, free_head_d;
	logic [LW-1:0] ready_head_q, ready_head_d;
	logic [LW-1:0] ready_tail_q, ready_tail_d;
	logic [FW-1:0] filling_q, filling_d;
	logic [FW-1:0] link2_addr_q;
	logic [CNT_W-1:0] stat_q [4];
	logic [3:0] inc;

	logic out_valid_q;
	rxpool_pkg::status_t res_status_q, res_status_d;
	logic [2:0] res_frame_q, res_frame_d;
	logic [LEN_W-1:0] res_len_q, res_len_d;

	logic accept;
	logic out_free;
	logic exec_go;
	logic need_link2;
	logic fidx_ok;
	logic cfg_we;

	logic rd_en;
	logic [LW-1:0] rd_sel;
	logic [FW-1:0] rd_addr;
	logic [LW-1:0] link_rdata;
	logic [LEN_W-1:0] len_rdata;
	logic link_we;
	logic [FW-1:0] link_waddr;
	logic [LW-1:0] link_wdata;
	logic len_we;
	logic [FW-1:0] len_waddr;
	logic [LEN_W-1:0] len_wdata;
	rxpool_pkg::fcs_cls_t cls;

	rxpool_fcs_check #(
		.MAX_BYTES(MAX_BYTES)
	) u_fcs (
		.byte_count (count_q),
		.crc_residue(residue_q),
		.max_len    (max_len_q),
		.cls        (cls)
	);

	rxpool_link_mem #(
		.FRAME_COUNT(FRAME_COUNT)
	) u_link (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(link_rdata),
		.wr_en  (link_we),
		.wr_addr(link_waddr),
		.wr_data(link_wdata)
	);

	rxpool_len_mem #(
		.FRAME_COUNT(FRAME_COUNT)
	) u_len (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(len_rdata),
		.wr_en  (len_we),
		.wr_addr(len_waddr),
		.wr_data(len_wdata)
	);

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr == rxpool_pkg::ADDR_MAX_LEN);
	assign prdata = (paddr == rxpool_pkg::ADDR_MAX_LEN) ? {20'b0, max_len_q} : '0;

	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign exec_go = (state_q == S_EXEC) && out_free;
	assign fidx_ok = int'(fidx_q) < FRAME_COUNT;

	assign rd_en = accept;
	assign rd_sel = (rxpool_pkg::op_t'(opcode) == rxpool_pkg::OP_TAKE) ? ready_head_q
		: free_head_q;
	assign rd_addr = (rd_sel < NIL) ? rd_sel[FW-1:0] : '0;

	assign out_valid = out_valid_q;
	assign status = res_status_q;
	assign result_frame = res_frame_q;
	assign result_length = res_len_q;
	assign good_packets = stat_q[0];
	assign overrun_count = stat_q[1];
	assign fcs_error_count = stat_q[2];
	assign oversize_count = stat_q[3];

	always_comb begin
		free_head_d = free_head_q;
		ready_head_d = ready_head_q;
		ready_tail_d = ready_tail_q;
		filling_d = filling_q;
		inc = '0;
		need_link2 = 1'b0;
		res_status_d = rxpool_pkg::ST_NONE;
		res_frame_d = '0;
		res_len_d = '0;
		link_we = 1'b0;
		link_waddr = filling_q;
		link_wdata = NIL;
		len_we = 1'b0;
		len_waddr = filling_q;
		len_wdata = cls.length;
		state_d = state_q;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_LINK2: begin
				link_we = 1'b1;
				link_waddr = link2_addr_q;
				link_wdata = ready_tail_q;
				state_d = S_IDLE;
			end
			S_EXEC: begin
				if (exec_go) begin
					case (op_q)
						rxpool_pkg::OP_PKT_END: begin
							res_frame_d = 3'(filling_q);
							if (free_head_q >= NIL) begin
								inc[1] = 1'b1;
								res_status_d = rxpool_pkg::ST_OVERRUN;
							end else begin
								free_head_d = link_rdata;
								filling_d = free_head_q[FW-1:0];
								len_we = 1'b1;
								res_len_d = cls.length;
								link_we = 1'b1;
								if (!cls.match || cls.oversize) begin
									link_wdata = link_rdata;
									free_head_d = LW'(filling_q);
									if (!cls.match) begin
										inc[2] = 1'b1;
										res_status_d = rxpool_pkg::ST_FCS;
									end else begin
										inc[3] = 1'b1;
										res_status_d = rxpool_pkg::ST_OVERSIZE;
									end
								end else begin
									link_wdata = NIL;
									inc[0] = 1'b1;
									res_status_d = rxpool_pkg::ST_QUEUED;
									ready_tail_d = LW'(filling_q);
									if (ready_tail_q < NIL) begin
										need_link2 = 1'b1;
									end else begin
										ready_head_d = LW'(filling_q);
									end
								end
							end
						end
						rxpool_pkg::OP_TAKE: begin
							if (ready_head_q < NIL) begin
								ready_head_d = link_rdata;
								if (link_rdata >= NIL) begin
									ready_tail_d = NIL;
								end
								res_status_d = rxpool_pkg::ST_GIVEN;
								res_frame_d = 3'(ready_head_q);
								res_len_d = len_rdata;
							end
						end
						rxpool_pkg::OP_RETURN: begin
							res_status_d = rxpool_pkg::ST_RETURNED;
							res_frame_d = fidx_q;
							if (fidx_ok) begin
								link_we = 1'b1;
								link_waddr = FW'(fidx_q);
								link_wdata = free_head_q;
								free_head_d = LW'(fidx_q);
							end
						end
						default: begin
							res_status_d = rxpool_pkg::ST_NONE;
						end
					endcase
					state_d = need_link2 ? S_LINK2 : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= rxpool_pkg::OP_PKT_END;
			count_q <= '0;
			residue_q <= '0;
			fidx_q <= '0;
			max_len_q <= rxpool_pkg::RESET_MAX_LEN;
			free_head_q <= LW'(1);
			ready_head_q <= NIL;
			ready_tail_q <= NIL;
			filling_q <= '0;
			link2_addr_q <= '0;
			for (int i = 0; i < 4; i++) begin
				stat_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
			res_status_q <= rxpool_pkg::ST_NONE;
			res_frame_q <= '0;
			res_len_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				max_len_q <= pwdata[LEN_W-1:0];
			end
			if (accept) begin
				op_q <= rxpool_pkg::op_t'(opcode);
				count_q <= byte_count;
				residue_q <= crc_residue;
				fidx_q <= frame_index;
			end
			free_head_q <= free_head_d;
			ready_head_q <= ready_head_d;
			ready_tail_q <= ready_tail_d;
			filling_q <= filling_d;
			if (need_link2) begin
				link2_addr_q <= ready_tail_q[FW-1:0];
			end
			for (int i = 0; i < 4; i++) begin
				stat_q[i] <= stat_q[i] + CNT_W'(inc[i]);
			end
			if (exec_go) begin
				out_valid_q <= 1'b1;
				res_status_q <= res_status_d;
				res_frame_q <= res_frame_d;
				res_len_q <= res_len_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: design/rxpool_checker.sv
// Port-level checks for the receive frame pool, bound to the top level.
// Depends on rxpool_pkg for the status codes.
`default_nettype none

module rxpool_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [2:0]  status,
	input wire logic [2:0]  result_frame,
	input wire logic [11:0] result_length,
	input wire logic [31:0] good_packets,
	input wire logic [31:0] overrun_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
			&& $stable(result_frame) && $stable(result_length))
		else $error("Stalled result word changed.");

	a_good_step: assert property (@(posedge clk) disable iff (!arst_n)
		(good_packets != $past(good_packets)) |->
			(good_packets == $past(good_packets) + 32'd1) && out_valid
			&& (status == rxpool_pkg::ST_QUEUED))
		else $error("Good packet count moved without a queued frame.");

	a_overrun_step: assert property (@(posedge clk) disable iff (!arst_n)
		(overrun_count != $past(overrun_count)) |->
			(overrun_count == $past(overrun_count) + 32'd1) && out_valid
			&& (status == rxpool_pkg::ST_OVERRUN))
		else $error("Overrun count moved without an overrun result.");

	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == rxpool_pkg::ST_OVERRUN || status == rxpool_pkg::ST_RETURNED
			|| status == rxpool_pkg::ST_NONE) |-> result_length == 12'd0)
		else $error("Result without a frame length carries a length.");

	a_none_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == rxpool_pkg::ST_NONE) |-> result_frame == 3'd0)
		else $error("Empty take names a frame.");

endmodule

bind mac_rx_frame_pool_fcs_check_top rxpool_checker u_rxpool_checker (.*);

`default_nettype wire
